@@ src/ttps_pkg.sv @@
// shared types and constants for the transposition table probe/store block
// field widths, command and bound codes, stored entry layout
// no dependencies
package ttps_pkg;

    localparam int unsigned DEFAULT_TABLE_ENTRIES = 65536;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned DEPTH_W = 6;
    localparam int unsigned SCORE_W = 16;
    localparam int unsigned MOVE_W  = 13;
    localparam int unsigned BOUND_W = 2;

    // key bits folded into the slot index per reduction step
    localparam int unsigned MOD_STEP_BITS = 8;
    localparam int unsigned MOD_STEPS     = KEY_W / MOD_STEP_BITS;
    localparam int unsigned MOD_CNT_W     = $clog2(MOD_STEPS);

    // command codes
    localparam logic CMD_PROBE = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    // bound codes as kept in the table
    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

    typedef struct packed {
        logic                       has_move;
        logic [MOVE_W-1:0]          move;
        logic [BOUND_W-1:0]         bound;
        logic signed [SCORE_W-1:0]  score;
        logic [DEPTH_W-1:0]         depth;
    } payload_t;

    typedef struct packed {
        payload_t           pl;
        logic [KEY_W-1:0]   key;
    } entry_t;

endpackage

@@ src/transposition_table_probe_store.sv @@
// Direct-mapped transposition table with depth-preferred replacement. Each
// slot (key plus packed payload) lives in one synchronous single-port-style
// memory of TABLE_ENTRIES entries; the slot index is the position key modulo
// TABLE_ENTRIES. After reset the block runs a clearing pass that zeroes one
// slot per cycle, with req_stall held high.
// One item is worked at a time: accept, key reduction when TABLE_ENTRIES is
// not a power of two (the 64-bit key is folded in 8 key bits per cycle),
// memory read, then evaluate and write back. The registered memory read and
// the read-modify-write of a slot set these steps. The result sits in an
// output register, so a new item is accepted while the previous result
// waits; evaluation holds only when that register is still full.
// depends on ttps_pkg
module transposition_table_probe_store #(
    parameter int unsigned TABLE_ENTRIES = ttps_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                req_valid,
    output logic                                req_stall,
    input  logic                                cmd,
    input  logic [ttps_pkg::KEY_W-1:0]          position_key,
    input  logic [ttps_pkg::DEPTH_W-1:0]        search_depth,
    input  logic signed [ttps_pkg::SCORE_W-1:0] window_low,
    input  logic signed [ttps_pkg::SCORE_W-1:0] window_high,
    input  logic signed [ttps_pkg::SCORE_W-1:0] node_score,
    input  logic [ttps_pkg::MOVE_W-1:0]         move_code,
    input  logic                                move_present,

    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output logic                                hit,
    output logic                                cutoff,
    output logic signed [ttps_pkg::SCORE_W-1:0] cutoff_score,
    output logic signed [ttps_pkg::SCORE_W-1:0] alpha_out,
    output logic signed [ttps_pkg::SCORE_W-1:0] beta_out,
    output logic [ttps_pkg::MOVE_W-1:0]         hint_move,
    output logic                                hint_valid,
    output logic                                written
);

    import ttps_pkg::*;

    localparam int unsigned IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam bit          IDX_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
    localparam logic [IDX_W:0]   ENTRIES_W = (IDX_W + 1)'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_ENTRIES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_EVAL
    } state_t;

    state_t                     state_reg;
    logic [IDX_W-1:0]           clr_cnt_reg;
    logic [MOD_CNT_W-1:0]       mod_cnt_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           idx_next;

    // captured request
    logic                       cmd_reg;
    logic [KEY_W-1:0]           key_reg;
    logic [DEPTH_W-1:0]         depth_reg;
    logic signed [SCORE_W-1:0]  alpha_reg;
    logic signed [SCORE_W-1:0]  beta_reg;
    logic signed [SCORE_W-1:0]  score_reg;
    logic [MOVE_W-1:0]          move_reg;
    logic                       mvp_reg;

    // result register
    logic                       rsp_valid_reg;
    logic                       hit_reg;
    logic                       cutoff_reg;
    logic signed [SCORE_W-1:0]  cutoff_score_reg;
    logic signed [SCORE_W-1:0]  alpha_out_reg;
    logic signed [SCORE_W-1:0]  beta_out_reg;
    logic [MOVE_W-1:0]          hint_move_reg;
    logic                       hint_valid_reg;
    logic                       written_reg;

    // slot memory
    entry_t                     slot_mem [TABLE_ENTRIES];
    entry_t                     rd_q;
    logic                       rd_en;
    logic                       wr_en;
    logic [IDX_W-1:0]           wr_addr;
    entry_t                     wr_data;

    // evaluation
    logic                       out_free;
    logic                       ev_hit;
    logic                       ev_cut;
    logic signed [SCORE_W-1:0]  ev_cut_score;
    logic signed [SCORE_W-1:0]  ev_alpha;
    logic signed [SCORE_W-1:0]  ev_beta;
    logic [BOUND_W-1:0]         st_bound;
    logic                       st_write;
    entry_t                     st_entry;

    assign req_stall = (state_reg != S_IDLE);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // key reduction: fold one byte of the key into the remainder per cycle
    always_comb
    begin
        logic [IDX_W:0]             rem;
        logic [MOD_STEP_BITS-1:0]   chunk;
        chunk = key_reg[(MOD_STEPS - 1 - 32'(mod_cnt_reg)) * MOD_STEP_BITS +: MOD_STEP_BITS];
        rem   = {1'b0, idx_reg};
        for (int b = MOD_STEP_BITS - 1; b >= 0; b--)
        begin
            rem = {rem[IDX_W-1:0], chunk[b]};
            if (rem >= ENTRIES_W)
            begin
                rem = rem - ENTRIES_W;
            end
        end
        idx_next = rem[IDX_W-1:0];
    end

    // probe evaluation against the slot read back
    always_comb
    begin
        logic deep;
        ev_hit       = (key_reg != '0) && (rd_q.key == key_reg);
        deep         = (rd_q.pl.depth >= depth_reg);
        ev_alpha     = alpha_reg;
        ev_beta      = beta_reg;
        ev_cut       = 1'b0;
        ev_cut_score = '0;
        if (ev_hit && deep)
        begin
            if (rd_q.pl.bound == BOUND_EXACT)
            begin
                ev_cut       = 1'b1;
                ev_cut_score = rd_q.pl.score;
            end
            else
            begin
                if (rd_q.pl.bound == BOUND_LOWER && rd_q.pl.score > alpha_reg)
                begin
                    ev_alpha = rd_q.pl.score;
                end
                if (rd_q.pl.bound == BOUND_UPPER && rd_q.pl.score < beta_reg)
                begin
                    ev_beta = rd_q.pl.score;
                end
                if (ev_alpha >= ev_beta)
                begin
                    ev_cut       = 1'b1;
                    ev_cut_score = rd_q.pl.score;
                end
            end
        end
    end

    // store: bound class, replacement decision and new entry
    always_comb
    begin
        priority if (score_reg <= alpha_reg)
        begin
            st_bound = BOUND_UPPER;
        end
        else if (score_reg >= beta_reg)
        begin
            st_bound = BOUND_LOWER;
        end
        else
        begin
            st_bound = BOUND_EXACT;
        end
        st_write = (key_reg != '0) &&
                   ((rd_q.key == '0) || (depth_reg >= rd_q.pl.depth));
        st_entry.key         = key_reg;
        st_entry.pl.depth    = depth_reg;
        st_entry.pl.score    = score_reg;
        st_entry.pl.bound    = st_bound;
        st_entry.pl.move     = mvp_reg ? move_reg : '0;
        st_entry.pl.has_move = mvp_reg;
    end

    // memory port control: clearing pass or write-back of a store
    always_comb
    begin
        rd_en = (state_reg == S_READ);
        if (state_reg == S_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = (state_reg == S_EVAL) && out_free && (cmd_reg == CMD_STORE) && st_write;
            wr_addr = idx_reg;
            wr_data = st_entry;
        end
    end

    // slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q <= slot_mem[idx_reg];
        end
    end

    // captured request fields
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req_valid)
        begin
            cmd_reg   <= cmd;
            key_reg   <= position_key;
            depth_reg <= search_depth;
            alpha_reg <= window_low;
            beta_reg  <= window_high;
            score_reg <= node_score;
            move_reg  <= move_code;
            mvp_reg   <= move_present;
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            mod_cnt_reg      <= '0;
            idx_reg          <= '0;
            rsp_valid_reg    <= 1'b0;
            hit_reg          <= 1'b0;
            cutoff_reg       <= 1'b0;
            cutoff_score_reg <= '0;
            alpha_out_reg    <= '0;
            beta_out_reg     <= '0;
            hint_move_reg    <= '0;
            hint_valid_reg   <= 1'b0;
            written_reg      <= 1'b0;
        end
        else
        begin
            // result valid: set by a finished item, else cleared once taken
            if (state_reg == S_EVAL && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == LAST_IDX)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        mod_cnt_reg <= '0;
                        if (IDX_POW2)
                        begin
                            idx_reg   <= position_key[IDX_W-1:0];
                            state_reg <= S_READ;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_MOD;
                        end
                    end
                end
                S_MOD:
                begin
                    idx_reg     <= idx_next;
                    mod_cnt_reg <= mod_cnt_reg + 1'b1;
                    if (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (out_free)
                    begin
                        if (cmd_reg == CMD_PROBE)
                        begin
                            hit_reg          <= ev_hit;
                            cutoff_reg       <= ev_cut;
                            cutoff_score_reg <= ev_cut_score;
                            alpha_out_reg    <= ev_alpha;
                            beta_out_reg     <= ev_beta;
                            hint_move_reg    <= ev_hit ? rd_q.pl.move : '0;
                            hint_valid_reg   <= ev_hit && rd_q.pl.has_move;
                            written_reg      <= 1'b0;
                        end
                        else
                        begin
                            hit_reg          <= 1'b0;
                            cutoff_reg       <= 1'b0;
                            cutoff_score_reg <= '0;
                            alpha_out_reg    <= '0;
                            beta_out_reg     <= '0;
                            hint_move_reg    <= '0;
                            hint_valid_reg   <= 1'b0;
                            written_reg      <= st_write;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign hit          = hit_reg;
    assign cutoff       = cutoff_reg;
    assign cutoff_score = cutoff_score_reg;
    assign alpha_out    = alpha_out_reg;
    assign beta_out     = beta_out_reg;
    assign hint_move    = hint_move_reg;
    assign hint_valid   = hint_valid_reg;
    assign written      = written_reg;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// testbench for the transposition table probe/store block: directed probes and stores,
// then random store/probe sequences checked against a shadow copy of the table
// depends on ttps_pkg and transposition_table_probe_store
module tb;
    import ttps_pkg::*;

    localparam longint unsigned TBL_N        = DEFAULT_TABLE_ENTRIES;
    localparam int              RANDOM_ITEMS = 1750;
    localparam int              IDLE_LIMIT   = int'(4 * TBL_N + 10000);
    localparam int              POOL_SLOTS   = 8;
    localparam int              KEYS_PER_SLOT = 3;
    localparam int              POOL_N       = POOL_SLOTS * KEYS_PER_SLOT;

    typedef struct packed {
        logic                       hit;
        logic                       cutoff;
        logic signed [SCORE_W-1:0]  cutoff_score;
        logic signed [SCORE_W-1:0]  alpha;
        logic signed [SCORE_W-1:0]  beta;
        logic [MOVE_W-1:0]          hint_move;
        logic                       hint_valid;
        logic                       written;
    } lookup_result_t;

    typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

    // shadow table and queue of awaited lookup results
    class probe_store_scoreboard;
        longint unsigned    table_size;
        logic [KEY_W-1:0]   shadow_key [longint unsigned];
        payload_t           shadow_payload [longint unsigned];
        lookup_result_t     awaited_results [$];
        int                 error_count;

        function new(longint unsigned entries);
            table_size  = entries;
            error_count = 0;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction

        // work out the result of one accepted item and update the shadow table
        function void note_request(logic c, logic [KEY_W-1:0] k, logic [DEPTH_W-1:0] d,
                                   logic signed [SCORE_W-1:0] lo,
                                   logic signed [SCORE_W-1:0] hi,
                                   logic signed [SCORE_W-1:0] sc,
                                   logic [MOVE_W-1:0] mv, logic mp);
            lookup_result_t             r;
            longint unsigned            slot;
            logic [KEY_W-1:0]           old_key;
            payload_t                   pl;
            logic signed [SCORE_W-1:0]  a;
            logic signed [SCORE_W-1:0]  b;
            logic [BOUND_W-1:0]         bnd;
            r    = '0;
            slot = k % table_size;
            old_key = shadow_key.exists(slot) ? shadow_key[slot] : '0;
            pl      = shadow_payload.exists(slot) ? shadow_payload[slot] : '0;
            if (c == CMD_PROBE)
            begin
                a = lo;
                b = hi;
                r.alpha = lo;
                r.beta  = hi;
                if (k != '0 && old_key == k)
                begin
                    r.hit        = 1'b1;
                    r.hint_move  = pl.move;
                    r.hint_valid = pl.has_move;
                    // stored entry deep enough to apply its bound
                    if (pl.depth >= d)
                    begin
                        if (pl.bound == BOUND_EXACT)
                        begin
                            r.cutoff       = 1'b1;
                            r.cutoff_score = pl.score;
                        end
                        else
                        begin
                            if (pl.bound == BOUND_LOWER && pl.score > a)
                                a = pl.score;
                            if (pl.bound == BOUND_UPPER && pl.score < b)
                                b = pl.score;
                            r.alpha = a;
                            r.beta  = b;
                            if (a >= b)
                            begin
                                r.cutoff       = 1'b1;
                                r.cutoff_score = pl.score;
                            end
                        end
                    end
                end
            end
            else
            begin
                // classify bound from the score against the window
                if (sc <= lo)
                    bnd = BOUND_UPPER;
                else if (sc >= hi)
                    bnd = BOUND_LOWER;
                else
                    bnd = BOUND_EXACT;
                // depth-preferred replacement, empty slots always taken
                if (k != '0 && (old_key == '0 || d >= pl.depth))
                begin
                    pl.depth    = d;
                    pl.score    = sc;
                    pl.bound    = bnd;
                    pl.move     = mp ? mv : '0;
                    pl.has_move = mp;
                    shadow_key[slot]     = k;
                    shadow_payload[slot] = pl;
                    r.written = 1'b1;
                end
            end
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, longint want, longint got);
            if (want != got)
            begin
                error_count++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // compare one accepted result with the oldest awaited one
        function void check_response(lookup_result_t got);
            lookup_result_t want;
            if (awaited_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result with none awaited, expected nothing, actual %h",
                         $time, got);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("cutoff", want.cutoff, got.cutoff);
            compare_field("cutoff_score", want.cutoff_score, got.cutoff_score);
            compare_field("alpha_out", want.alpha, got.alpha);
            compare_field("beta_out", want.beta, got.beta);
            compare_field("hint_move", want.hint_move, got.hint_move);
            compare_field("hint_valid", want.hint_valid, got.hint_valid);
            compare_field("written", want.written, got.written);
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       req_valid;
    logic                       req_stall;
    logic                       cmd;
    logic [KEY_W-1:0]           position_key;
    logic [DEPTH_W-1:0]         search_depth;
    logic signed [SCORE_W-1:0]  window_low;
    logic signed [SCORE_W-1:0]  window_high;
    logic signed [SCORE_W-1:0]  node_score;
    logic [MOVE_W-1:0]          move_code;
    logic                       move_present;
    logic                       rsp_valid;
    logic                       rsp_stall = 1'b0;
    logic                       hit;
    logic                       cutoff;
    logic signed [SCORE_W-1:0]  cutoff_score;
    logic signed [SCORE_W-1:0]  alpha_out;
    logic signed [SCORE_W-1:0]  beta_out;
    logic [MOVE_W-1:0]          hint_move;
    logic                       hint_valid;
    logic                       written;

    probe_store_scoreboard  sb;
    int                     burst_left;
    int                     idle_cycles = 0;
    stall_mode_t            stall_mode = STALL_NONE;
    int                     stall_left = 0;
    logic [KEY_W-1:0]       key_pool [0:POOL_N-1];

    transposition_table_probe_store #(
        .TABLE_ENTRIES(32'(TBL_N))
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .cmd(cmd),
        .position_key(position_key),
        .search_depth(search_depth),
        .window_low(window_low),
        .window_high(window_high),
        .node_score(node_score),
        .move_code(move_code),
        .move_present(move_present),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .hit(hit),
        .cutoff(cutoff),
        .cutoff_score(cutoff_score),
        .alpha_out(alpha_out),
        .beta_out(beta_out),
        .hint_move(hint_move),
        .hint_valid(hint_valid),
        .written(written)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watch both channels at each edge
    always @(posedge clk)
    begin
        if (req_valid && !req_stall)
            sb.note_request(cmd, position_key, search_depth, window_low, window_high,
                            node_score, move_code, move_present);
        if (rsp_valid && !rsp_stall)
            sb.check_response({hit, cutoff, cutoff_score, alpha_out, beta_out,
                               hint_move, hint_valid, written});
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    // receiver stall pattern, mode redrawn at random whenever its run ends
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_SPARSE:   rsp_stall <= ($urandom_range(0, 99) < 30);
            STALL_PERIODIC: rsp_stall <= (stall_left % 4 == 0);
            default:        rsp_stall <= ($urandom_range(0, 99) < 70);
        endcase
    end

    // watchdog on cycles with no item moving
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("transposition_table_probe_store test failed");
        $finish;
    end

    // drive one item, with a random gap at the start of each burst
    task automatic send_request(logic c, logic [KEY_W-1:0] k, logic [DEPTH_W-1:0] d,
                                logic signed [SCORE_W-1:0] lo,
                                logic signed [SCORE_W-1:0] hi,
                                logic signed [SCORE_W-1:0] sc,
                                logic [MOVE_W-1:0] mv, logic mp);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_valid    <= 1'b1;
        cmd          <= c;
        position_key <= k;
        search_depth <= d;
        window_low   <= lo;
        window_high  <= hi;
        node_score   <= sc;
        move_code    <= mv;
        move_present <= mp;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // scores mostly close together so bounds and cutoffs interact
    function automatic logic signed [SCORE_W-1:0] pick_score();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 14)
            return 16'($urandom_range(0, 80)) - 16'sd40;
        if (sel < 17)
            return 16'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh8001;
            default: return 16'sh7FFE;
        endcase
    endfunction

    function automatic logic [DEPTH_W-1:0] pick_depth();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 16)
            return 6'($urandom_range(0, 12));
        if (sel < 18)
            return 6'($urandom_range(0, 63));
        return 6'(63 - $urandom_range(0, 1));
    endfunction

    // mostly open windows, some closed ones
    function automatic void pick_window(output logic signed [SCORE_W-1:0] lo,
                                        output logic signed [SCORE_W-1:0] hi);
        logic signed [SCORE_W-1:0] t;
        lo = pick_score();
        hi = pick_score();
        if ($urandom_range(0, 9) < 7 && lo > hi)
        begin
            t  = lo;
            lo = hi;
            hi = t;
        end
    endfunction

    // keys from a small pool sharing slots, plus empty and fully random keys
    function automatic logic [KEY_W-1:0] pick_key();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return '0;
        if (sel < 3)
            return {$urandom, $urandom};
        return key_pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    // random traffic: stores followed by probes of the same position, plus noise
    task automatic run_random_traffic();
        int                         live_items;
        int                         n_probe;
        logic                       c;
        logic [KEY_W-1:0]           k;
        logic [DEPTH_W-1:0]         d;
        logic [DEPTH_W-1:0]         dp;
        logic signed [SCORE_W-1:0]  lo;
        logic signed [SCORE_W-1:0]  hi;
        live_items = 0;
        while (live_items < RANDOM_ITEMS)
        begin
            k = pick_key();
            d = pick_depth();
            if ($urandom_range(0, 9) < 7)
            begin
                pick_window(lo, hi);
                send_request(CMD_STORE, k, d, lo, hi, pick_score(),
                             13'($urandom), 1'($urandom));
                if (k != '0)
                    live_items++;
                n_probe = $urandom_range(1, 3);
                repeat (n_probe)
                begin
                    if ($urandom_range(0, 3) == 0)
                        dp = pick_depth();
                    else if (d > 0)
                        dp = d - 6'($urandom_range(0, 1));
                    else
                        dp = d;
                    pick_window(lo, hi);
                    send_request(CMD_PROBE, k, dp, lo, hi, pick_score(),
                                 13'($urandom), 1'($urandom));
                    live_items++;
                end
            end
            else
            begin
                c = 1'($urandom);
                pick_window(lo, hi);
                send_request(c, k, d, lo, hi, pick_score(), 13'($urandom), 1'($urandom));
                if (c == CMD_PROBE || k != '0)
                    live_items++;
            end
        end
    endtask

    // main sequence
    initial
    begin
        sb = new(TBL_N);
        burst_left = 0;
        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        cmd          <= CMD_PROBE;
        position_key <= '0;
        search_depth <= '0;
        window_low   <= '0;
        window_high  <= '0;
        node_score   <= '0;
        move_code    <= '0;
        move_present <= 1'b0;
        for (int i = 0; i < POOL_N; i++)
        begin
            case (i / KEYS_PER_SLOT)
                0:       key_pool[i] = {$urandom, 16'($urandom), 16'h0000};
                1:       key_pool[i] = {$urandom, 16'($urandom), 16'hFFFF};
                default: key_pool[i] = {$urandom, 16'($urandom),
                                        16'($urandom_range(0, 65535))};
            endcase
            // keep keys in the same group on one slot
            if (i % KEYS_PER_SLOT != 0)
                key_pool[i][15:0] = key_pool[i - 1][15:0];
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // key zero is never a hit and never stored
        send_request(CMD_PROBE, 64'h0, 6'd0, -16'sd5, 16'sd5, 16'sd0, 13'h0, 1'b0);
        send_request(CMD_STORE, 64'h0, 6'd63, -16'sd5, 16'sd5, 16'sd0, 13'h1FFF, 1'b1);
        send_request(CMD_PROBE, 64'h0, 6'd0, -16'sd5, 16'sd5, 16'sd0, 13'h0, 1'b0);
        // empty slot, then exact entry with full-width move
        send_request(CMD_PROBE, 64'h0123_4567_89AB_1234, 6'd0, -16'sd100, 16'sd100,
                     16'sd0, 13'h0, 1'b0);
        send_request(CMD_STORE, 64'h0123_4567_89AB_1234, 6'd10, -16'sd10, 16'sd10,
                     16'sd0, 13'h1FFF, 1'b1);
        send_request(CMD_PROBE, 64'h0123_4567_89AB_1234, 6'd10, -16'sd50, 16'sd50,
                     16'sd0, 13'h0, 1'b0);
        // shallow entry leaves the window alone
        send_request(CMD_PROBE, 64'h0123_4567_89AB_1234, 6'd11, -16'sd50, 16'sd50,
                     16'sd0, 13'h0, 1'b0);
        // lower bound without a move
        send_request(CMD_STORE, 64'h5555_AAAA_5555_0042, 6'd5, -16'sd10, 16'sd10,
                     16'sd20, 13'h0AAA, 1'b0);
        send_request(CMD_PROBE, 64'h5555_AAAA_5555_0042, 6'd5, -16'sd10, 16'sd30,
                     16'sd0, 13'h0, 1'b0);
        send_request(CMD_PROBE, 64'h5555_AAAA_5555_0042, 6'd0, -16'sd10, 16'sd15,
                     16'sd0, 13'h0, 1'b0);
        // closed window with a bound that changes nothing
        send_request(CMD_PROBE, 64'h5555_AAAA_5555_0042, 6'd0, 16'sd40, 16'sd30,
                     16'sd0, 13'h0, 1'b0);
        // upper bound
        send_request(CMD_STORE, 64'h8000_0000_0000_7FFF, 6'd7, -16'sd10, 16'sd10,
                     -16'sd20, 13'h0155, 1'b1);
        send_request(CMD_PROBE, 64'h8000_0000_0000_7FFF, 6'd7, -16'sd30, 16'sd10,
                     16'sd0, 13'h0, 1'b0);
        send_request(CMD_PROBE, 64'h8000_0000_0000_7FFF, 6'd3, 16'sd0, 16'sd5,
                     16'sd0, 13'h0, 1'b0);
        // shallower store into an occupied slot is refused, equal depth replaces
        send_request(CMD_STORE, 64'hFEDC_BA98_7654_1234, 6'd9, -16'sd10, 16'sd10,
                     16'sd3, 13'h0ABC, 1'b1);
        send_request(CMD_PROBE, 64'h0123_4567_89AB_1234, 6'd0, -16'sd50, 16'sd50,
                     16'sd0, 13'h0, 1'b0);
        send_request(CMD_STORE, 64'hFEDC_BA98_7654_1234, 6'd10, -16'sd10, 16'sd10,
                     16'sd3, 13'h0ABC, 1'b1);
        send_request(CMD_PROBE, 64'h0123_4567_89AB_1234, 6'd0, -16'sd50, 16'sd50,
                     16'sd0, 13'h0, 1'b0);
        send_request(CMD_PROBE, 64'hFEDC_BA98_7654_1234, 6'd10, -16'sd50, 16'sd50,
                     16'sd0, 13'h0, 1'b0);
        // extremes of key, depth and score
        send_request(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 16'sh7FFF, 16'sh8000,
                     16'sh8000, 13'h1FFF, 1'b1);
        send_request(CMD_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 16'sh8000, 16'sh7FFF,
                     16'sd0, 13'h0, 1'b0);
        send_request(CMD_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 16'sh8000, 16'sh7FFF,
                     16'sh7FFF, 13'h0, 1'b1);
        send_request(CMD_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 16'sh8000, 16'sh7FFF,
                     16'sd0, 13'h0, 1'b0);

        run_random_traffic();
        req_valid <= 1'b0;

        // drain outstanding results, then wait for stray ones
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);
        if (sb.error_count == 0 && sb.outstanding() == 0)
            $display("transposition_table_probe_store test passed");
        else
            $display("transposition_table_probe_store test failed");
        $finish;
    end
endmodule

@@ filelist.f @@
src/ttps_pkg.sv
src/transposition_table_probe_store.sv
sim/tb.sv
